@@ rtl/core/acdla_pkg.sv @@
package acdla_pkg;

  localparam int unsigned MAX_SLOTS = 6;
  localparam int unsigned CHAN_W    = 5;
  localparam int unsigned SAMPLE_W  = 11;
  localparam int unsigned ACC_W     = 15;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CENT_W    = 16;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [ACC_W-1:0] CENTER_RESET = 15'd7776;
  localparam logic [ACC_W-1:0] ACC_MAX      = 15'h7FFF;

  localparam logic [REG_IDX_W-1:0] REG_CENTER = 3'd6;

  typedef logic [MAX_SLOTS-1:0][CHAN_W-1:0] chan_map_t;

  typedef struct packed {
    logic                matched;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

endpackage

@@ rtl/core/acdla_front.sv @@
module acdla_front import acdla_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 6
) (
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,   // scan_word
  input  chan_map_t     chan_map_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output item_t         q_item_o
);

  logic [CHAN_W-1:0] chan;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;

  assign chan = s_axis_tdata[SAMPLE_W +: CHAN_W];

  // highest matching slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (chan_map_i[i] == chan) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  assign s_axis_tready    = !q_full_i;
  assign q_push_o         = s_axis_tvalid && !q_full_i;
  assign q_item_o.matched = hit;
  assign q_item_o.slot    = hit_slot;
  assign q_item_o.sample  = s_axis_tdata[SAMPLE_W-1:0];

endmodule

@@ rtl/core/acdla_fifo.sv @@
module acdla_fifo import acdla_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 2'd1)
    else $error("queue count lost a push");
`endif

endmodule

@@ rtl/core/acdla_back.sv @@
module acdla_back import acdla_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  input  logic [ACC_W-1:0] center_i,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // slot, filtered, centered, zero pad
  output logic             m_axis_tuser    // matched
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [ACC_W-1:0]  acc_q [NUM_SLOTS];
  logic [ACC_W-1:0]  acc_rd;
  logic [ACC_W+3:0]  acc_x15;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  acc_new;
  logic [CENT_W-1:0] cent_new;
  logic [IDX_W-1:0]  idx;

  logic              vld_q;
  logic              matched_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ACC_W-1:0]  filt_q;
  logic [CENT_W-1:0] cent_q;

  assign q_pop_o = !q_empty_i && (!vld_q || m_axis_tready);
  assign idx     = q_item_i.slot[IDX_W-1:0];
  assign acc_rd  = acc_q[idx];

  // floor(acc * 15 / 16) + sample, saturated
  always_comb begin
    acc_x15 = {acc_rd, 4'b0000} - {4'b0000, acc_rd};
    sum     = {1'b0, acc_x15[ACC_W+3:4]} + (ACC_W+1)'(q_item_i.sample);
    acc_new = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    cent_new = {1'b0, acc_new} - {1'b0, center_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (q_pop_o && q_item_i.matched) begin
      acc_q[idx] <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (q_pop_o) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      matched_q <= q_item_i.matched;
      slot_q    <= q_item_i.matched ? q_item_i.slot : '0;
      filt_q    <= q_item_i.matched ? acc_new : '0;
      cent_q    <= q_item_i.matched ? cent_new : '0;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = matched_q;
  assign m_axis_tdata  = {6'b000000, cent_q, filt_q, slot_q};

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> m_axis_tvalid) else $error("popped beat not presented");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
    else $error("unmatched beat carries data");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.matched) |-> q_item_i.slot < SLOT_W'(NUM_SLOTS))
    else $error("slot beyond configured count");
  a_acc_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.matched) |=> acc_q[$past(idx)] == filt_q)
    else $error("accumulator and output disagree");
`endif

endmodule

@@ rtl/core/adc_channel_demux_leaky_average_unit.sv @@
// Per-channel leaky averager for ADC scan words. Each input beat carries one
// scan word (channel in bits 15:11, sample in bits 10:0); the channel is
// matched against the slot channel registers, the highest matching slot
// wins, and its accumulator becomes floor(acc*15/16) + sample (saturated at
// 32767). Every input beat gives exactly one output beat: tuser is the match
// flag, tdata carries slot, new accumulator and accumulator minus
// center_offset; an unmatched beat returns all zero and changes nothing.
// Throughput is one beat per clock while m_axis_tready is high. A two-entry queue
// separates the channel matcher from the accumulator bank; each beat is registered
// in the queue, then the bank updates its accumulator and output register on pop.
// Registers (4-byte stride): slot0..slot5 channel at 0x00..0x14, center at 0x18.
module adc_channel_demux_leaky_average_unit import acdla_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // scan_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // slot[2:0], filtered[17:3], centered[33:18]
  output logic        m_axis_tuser    // matched
);

  chan_map_t            chan_q;
  logic [ACC_W-1:0]     center_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  logic  q_push, q_pop, q_full, q_empty;
  item_t q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        chan_q[i] <= CHAN_W'(i);
      end
      center_q <= CENTER_RESET;
    end else if (wr_en) begin
      if (reg_idx == REG_CENTER) begin
        center_q <= pwdata[ACC_W-1:0];
      end else if (reg_idx < REG_IDX_W'(MAX_SLOTS)) begin
        chan_q[reg_idx] <= pwdata[CHAN_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CENTER) begin
      prdata = 32'(center_q);
    end else if (reg_idx < REG_IDX_W'(MAX_SLOTS)) begin
      prdata = 32'(chan_q[reg_idx]);
    end
  end

  acdla_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .chan_map_i   (chan_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_in)
  );

  acdla_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_item_i(q_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_item_o (q_out)
  );

  acdla_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .center_i     (center_q),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
